// File: hw/rtl/ilte_pkg.sv
// ----------------------------------------------------------------------------
// ilte_pkg
// Shared widths, register indexes, payload types, controller states and the
// command and status groups of the interface line-tension energy unit.
// ----------------------------------------------------------------------------
`default_nettype none

package ilte_pkg;

   // Coordinate width used for the difference arithmetic.
   localparam int COORD_BITS = 32;
   localparam int FIELD_W    = 32;
   localparam int DIFF_W     = COORD_BITS + 1;
   localparam int ROOT_W     = DIFF_W + 1;
   localparam int SQ_W       = 2 * ROOT_W;
   localparam int REM_W      = ROOT_W + 3;
   localparam int BOX_W      = 31;
   localparam int LEN_W      = 48;
   localparam int HALF_W     = LEN_W / 2;
   localparam int TEN_W      = 32;
   localparam int MUL_W      = (DIFF_W > TEN_W) ? DIFF_W : TEN_W;
   localparam int PROD_W     = 2 * MUL_W;
   localparam int FULL_W     = PROD_W + HALF_W;
   localparam int EN_W       = 64;
   localparam int ADD_W      = ((ROOT_W > LEN_W) ? ROOT_W : LEN_W) + 1;
   localparam int STEP_W     = $clog2(ROOT_W + 1);
   localparam int CSR_ADDR_W = 4;
   localparam int CSR_DATA_W = 32;

   // Register indexes, taken from paddr[3:2].
   localparam logic [1:0] REG_TENSION = 2'd0;
   localparam logic [1:0] REG_BOX_X   = 2'd1;
   localparam logic [1:0] REG_BOX_Y   = 2'd2;
   localparam logic [1:0] REG_BOX_Z   = 2'd3;

   localparam logic [1:0] AXIS_X = 2'd0;
   localparam logic [1:0] AXIS_Y = 2'd1;
   localparam logic [1:0] AXIS_Z = 2'd2;

   typedef struct packed {
      logic signed [FIELD_W-1:0] node_x;
      logic signed [FIELD_W-1:0] node_y;
      logic signed [FIELD_W-1:0] node_z;
      logic signed [FIELD_W-1:0] nbr_x;
      logic signed [FIELD_W-1:0] nbr_y;
      logic signed [FIELD_W-1:0] nbr_z;
      logic                      node_in_a;
      logic                      nbr_in_a;
      logic                      periodic;
      logic                      empty_node;
      logic                      last_edge;
      logic                      last_node;
   } req_type;

   typedef struct packed {
      logic signed [EN_W-1:0] node_energy;
      logic signed [EN_W-1:0] total_energy;
      logic                   total_valid;
   } rsp_type;

   typedef struct packed {
      logic [TEN_W-1:0] tension;
      logic [BOX_W-1:0] box_x;
      logic [BOX_W-1:0] box_y;
      logic [BOX_W-1:0] box_z;
   } cfg_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_DECIDE,
      ST_DIFF,
      ST_MOD,
      ST_WRAP,
      ST_SQ,
      ST_ACC,
      ST_ROOT,
      ST_LEN,
      ST_MLO,
      ST_MHI,
      ST_SAT,
      ST_NEG,
      ST_ESUM,
      ST_OUT
   } state_type;

   typedef struct packed {
      logic       load;
      logic       diff;
      logic       mod_step;
      logic       wrap;
      logic       sq;
      logic       acc;
      logic       root_step;
      logic       len;
      logic       mlo;
      logic       mhi;
      logic       sat;
      logic       neg;
      logic       esum;
      logic       out_load;
      logic [1:0] axis;
   } cmd_type;

   typedef struct packed {
      logic mixed;
      logic empty;
      logic ends;
      logic wrap;
      logic slot_free;
   } stat_type;

endpackage

`default_nettype wire

// File: hw/rtl/ilte_csr.sv
// ----------------------------------------------------------------------------
// ilte_csr
// APB-style register file holding the tension and the three box lengths.
// ----------------------------------------------------------------------------
`default_nettype none

module ilte_csr (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               csr_psel,
   input  wire logic                               csr_penable,
   input  wire logic                               csr_pwrite,
   input  wire logic [ilte_pkg::CSR_ADDR_W-1:0]    csr_paddr,
   input  wire logic [ilte_pkg::CSR_DATA_W-1:0]    csr_pwdata,
   output logic      [ilte_pkg::CSR_DATA_W-1:0]    csr_prdata,
   output logic                                    csr_pready,
   output ilte_pkg::cfg_type                       cfg
);
   import ilte_pkg::*;

   cfg_type    cfg_ff, cfg_in;
   logic       wr_en;
   logic [1:0] idx;

   assign idx        = csr_paddr[3:2];
   assign wr_en      = csr_psel && csr_penable && csr_pwrite;
   assign csr_pready = 1'b1;
   assign cfg        = cfg_ff;

   // Register write decode.
   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         case (idx)
            REG_TENSION: cfg_in.tension = csr_pwdata;
            REG_BOX_X:   cfg_in.box_x   = csr_pwdata[BOX_W-1:0];
            REG_BOX_Y:   cfg_in.box_y   = csr_pwdata[BOX_W-1:0];
            REG_BOX_Z:   cfg_in.box_z   = csr_pwdata[BOX_W-1:0];
            default:     cfg_in = cfg_ff;
         endcase
      end
   end

   // Read mux.
   always_comb begin
      case (idx)
         REG_TENSION: csr_prdata = cfg_ff.tension;
         REG_BOX_X:   csr_prdata = CSR_DATA_W'(cfg_ff.box_x);
         REG_BOX_Y:   csr_prdata = CSR_DATA_W'(cfg_ff.box_y);
         REG_BOX_Z:   csr_prdata = CSR_DATA_W'(cfg_ff.box_z);
         default:     csr_prdata = '0;
      endcase
   end

   // The tension resets to 1.0 in Q16.16.
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.tension <= TEN_W'(65536);
         cfg_ff.box_x   <= '0;
         cfg_ff.box_y   <= '0;
         cfg_ff.box_z   <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

`default_nettype wire

// File: hw/rtl/ilte_ctrl.sv
// ----------------------------------------------------------------------------
// ilte_ctrl
// Sequencer that steps the datapath through wrap, square, root and energy.
// ----------------------------------------------------------------------------
`default_nettype none

module ilte_ctrl (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_stall,
   input  wire ilte_pkg::stat_type stat,
   output ilte_pkg::cmd_type       cmd
);
   import ilte_pkg::*;

   state_type           state_ff, state_in;
   logic [STEP_W-1:0]   step_ff, step_in;
   logic [1:0]          axis_ff, axis_in;
   logic                mod_last, root_last;

   assign mod_last  = (step_ff == STEP_W'(DIFF_W - 1));
   assign root_last = (step_ff == STEP_W'(ROOT_W - 1));
   assign req_stall = (state_ff != ST_IDLE);

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE:   if (req_valid) state_in = ST_DECIDE;
         ST_DECIDE: begin
            if (stat.empty)      state_in = ST_MLO;
            else if (stat.mixed) state_in = ST_DIFF;
            else if (stat.ends)  state_in = ST_MLO;
            else                 state_in = ST_IDLE;
         end
         ST_DIFF:   state_in = stat.wrap ? ST_MOD : ST_WRAP;
         ST_MOD:    if (mod_last) state_in = ST_WRAP;
         ST_WRAP:   state_in = ST_SQ;
         ST_SQ:     state_in = ST_ACC;
         ST_ACC:    state_in = (axis_ff == AXIS_Z) ? ST_ROOT : ST_DIFF;
         ST_ROOT:   if (root_last) state_in = ST_LEN;
         ST_LEN:    state_in = stat.ends ? ST_MLO : ST_IDLE;
         ST_MLO:    state_in = ST_MHI;
         ST_MHI:    state_in = ST_SAT;
         ST_SAT:    state_in = ST_NEG;
         ST_NEG:    state_in = ST_ESUM;
         ST_ESUM:   state_in = ST_OUT;
         ST_OUT:    if (stat.slot_free) state_in = ST_IDLE;
         default:   state_in = ST_IDLE;
      endcase
   end

   // Step and axis counters.
   always_comb begin
      step_in = '0;
      if ((state_ff == ST_MOD && !mod_last) || (state_ff == ST_ROOT && !root_last)) begin
         step_in = step_ff + 1'b1;
      end
      axis_in = axis_ff;
      if (state_ff == ST_DECIDE) axis_in = AXIS_X;
      else if (state_ff == ST_ACC) axis_in = axis_ff + 1'b1;
   end

   // Command outputs.
   always_comb begin
      cmd           = '0;
      cmd.axis      = axis_ff;
      cmd.load      = (state_ff == ST_IDLE) && req_valid;
      cmd.diff      = (state_ff == ST_DIFF);
      cmd.mod_step  = (state_ff == ST_MOD);
      cmd.wrap      = (state_ff == ST_WRAP);
      cmd.sq        = (state_ff == ST_SQ);
      cmd.acc       = (state_ff == ST_ACC);
      cmd.root_step = (state_ff == ST_ROOT);
      cmd.len       = (state_ff == ST_LEN);
      cmd.mlo       = (state_ff == ST_MLO);
      cmd.mhi       = (state_ff == ST_MHI);
      cmd.sat       = (state_ff == ST_SAT);
      cmd.neg       = (state_ff == ST_NEG);
      cmd.esum      = (state_ff == ST_ESUM);
      cmd.out_load  = (state_ff == ST_OUT) && stat.slot_free;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         step_ff  <= '0;
         axis_ff  <= AXIS_X;
      end else begin
         state_ff <= state_in;
         step_ff  <= step_in;
         axis_ff  <= axis_in;
      end
   end

endmodule

`default_nettype wire

// File: hw/rtl/ilte_dp.sv
// ----------------------------------------------------------------------------
// ilte_dp
// Datapath: axis wrap by serial remainder, shared multiplier, serial square
// root, saturating length and energy sums and the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module ilte_dp (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire ilte_pkg::req_type  req_data,
   output logic                    rsp_valid,
   input  wire logic               rsp_stall,
   output ilte_pkg::rsp_type       rsp_data,
   input  wire ilte_pkg::cfg_type  cfg,
   input  wire ilte_pkg::cmd_type  cmd,
   output ilte_pkg::stat_type      stat
);
   import ilte_pkg::*;

   localparam logic [LEN_W-1:0] LEN_MAX = '1;
   localparam logic [EN_W-1:0]  S64_MAX = {1'b0, {(EN_W-1){1'b1}}};
   localparam logic [EN_W-1:0]  S64_MIN = {1'b1, {(EN_W-1){1'b0}}};

   // Captured item.
   req_type            item_ff;
   // Axis arithmetic.
   logic [DIFF_W-1:0]  absd_ff, div_ff, mag_ff;
   logic [BOX_W-1:0]   mrem_ff;
   // Squares and root.
   logic [PROD_W-1:0]  prod_ff, plo_ff;
   logic [SQ_W-1:0]    sq_ff;
   logic [ROOT_W-1:0]  root_ff;
   logic [REM_W-3:0]   rrem_ff;
   // Sums and energy.
   logic [LEN_W-1:0]   len_ff;
   logic [EN_W-1:0]    p_ff, e_ff, es_ff;
   rsp_type            rsp_ff;
   logic               rsp_valid_ff, rsp_valid_in;

   logic [BOX_W-1:0]          box;
   logic [FIELD_W-1:0]        ca, cb;
   logic signed [DIFF_W-1:0]  d;
   logic [DIFF_W-1:0]         absd;
   logic [BOX_W:0]            mrem_t;
   logic [BOX_W-1:0]          half, mag_w;
   logic [MUL_W-1:0]          mul_a, mul_b;
   logic [PROD_W-1:0]         prod;
   logic [REM_W-1:0]          rrem_t, trial;
   logic [ADD_W-1:0]          len_sum;
   logic [TEN_W-1:0]          tmag;
   logic                      tneg;
   logic [FULL_W-1:0]         full;
   logic [FULL_W-1:0]         lim;
   logic [EN_W:0]             es_sum;
   logic [EN_W-1:0]           es_sat, es_rnd;

   function automatic logic signed [DIFF_W-1:0] coord_ext(input logic [FIELD_W-1:0] v);
      logic signed [COORD_BITS-1:0] c;
      c = COORD_BITS'(v);
      return DIFF_W'(c);
   endfunction

   // Status towards the controller.
   always_comb begin
      stat.mixed     = item_ff.node_in_a ^ item_ff.nbr_in_a;
      stat.empty     = item_ff.empty_node;
      stat.ends      = item_ff.empty_node || item_ff.last_edge;
      stat.wrap      = item_ff.periodic && (box != '0);
      stat.slot_free = !rsp_valid_ff || !rsp_stall;
   end

   // Axis selection.
   always_comb begin
      case (cmd.axis)
         AXIS_X:  begin box = cfg.box_x; ca = item_ff.node_x; cb = item_ff.nbr_x; end
         AXIS_Y:  begin box = cfg.box_y; ca = item_ff.node_y; cb = item_ff.nbr_y; end
         AXIS_Z:  begin box = cfg.box_z; ca = item_ff.node_z; cb = item_ff.nbr_z; end
         default: begin box = cfg.box_z; ca = item_ff.node_z; cb = item_ff.nbr_z; end
      endcase
   end

   // Axis difference, remainder step and minimum image.
   always_comb begin
      d      = coord_ext(ca) - coord_ext(cb);
      absd   = d[DIFF_W-1] ? DIFF_W'(-d) : DIFF_W'(d);
      mrem_t = {mrem_ff, div_ff[DIFF_W-1]};
      half   = box >> 1;
      mag_w  = (mrem_ff > half) ? (box - mrem_ff) : mrem_ff;
   end

   // Shared multiplier.
   always_comb begin
      tneg = cfg.tension[TEN_W-1];
      tmag = tneg ? (~cfg.tension + 1'b1) : cfg.tension;
      if (cmd.sq) begin
         mul_a = MUL_W'(mag_ff);
         mul_b = MUL_W'(mag_ff);
      end else if (cmd.mlo) begin
         mul_a = MUL_W'(tmag);
         mul_b = MUL_W'(len_ff[HALF_W-1:0]);
      end else begin
         mul_a = MUL_W'(tmag);
         mul_b = MUL_W'(len_ff[LEN_W-1:HALF_W]);
      end
      prod = mul_a * mul_b;
   end

   // Square root step and saturating arithmetic.
   always_comb begin
      rrem_t  = {rrem_ff, sq_ff[SQ_W-1:SQ_W-2]};
      trial   = REM_W'({root_ff, 2'b01});
      len_sum = ADD_W'(len_ff) + ADD_W'(root_ff);
      full    = (FULL_W'(prod_ff) << HALF_W) + FULL_W'(plo_ff);
      lim     = tneg ? FULL_W'(S64_MIN) : FULL_W'(S64_MAX);
      es_sum  = {e_ff[EN_W-1], e_ff} + {es_ff[EN_W-1], es_ff};
      if (es_sum[EN_W] != es_sum[EN_W-1]) es_sat = es_sum[EN_W] ? S64_MIN : S64_MAX;
      else                                es_sat = es_sum[EN_W-1:0];
      // Halving rounds toward zero.
      es_rnd  = es_ff + EN_W'(es_ff[EN_W-1]);
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // Result handshake.
   always_comb begin
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      if (cmd.out_load) rsp_valid_in = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         len_ff       <= '0;
         es_ff        <= '0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (cmd.len) begin
            len_ff <= (len_sum > ADD_W'(LEN_MAX)) ? LEN_MAX : len_sum[LEN_W-1:0];
         end
         if (cmd.esum) begin
            es_ff  <= es_sat;
            len_ff <= '0;
         end
         if (cmd.out_load && item_ff.last_node) es_ff <= '0;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         item_ff <= req_data;
         sq_ff   <= '0;
         root_ff <= '0;
         rrem_ff <= '0;
      end
      if (cmd.diff) begin
         absd_ff <= absd;
         div_ff  <= absd;
         mrem_ff <= '0;
      end
      if (cmd.mod_step) begin
         mrem_ff <= (mrem_t >= {1'b0, box}) ? BOX_W'(mrem_t - {1'b0, box}) : BOX_W'(mrem_t);
         div_ff  <= div_ff << 1;
      end
      if (cmd.wrap) mag_ff <= stat.wrap ? DIFF_W'(mag_w) : absd_ff;
      if (cmd.sq || cmd.mlo) prod_ff <= prod;
      if (cmd.mhi) begin
         plo_ff  <= prod_ff;
         prod_ff <= prod;
      end
      if (cmd.acc) sq_ff <= sq_ff + SQ_W'(prod_ff);
      if (cmd.root_step) begin
         if (rrem_t >= trial) begin
            rrem_ff <= (REM_W-2)'(rrem_t - trial);
            root_ff <= {root_ff[ROOT_W-2:0], 1'b1};
         end else begin
            rrem_ff <= (REM_W-2)'(rrem_t);
            root_ff <= {root_ff[ROOT_W-2:0], 1'b0};
         end
         sq_ff <= sq_ff << 2;
      end
      if (cmd.sat) p_ff <= (full > lim) ? lim[EN_W-1:0] : full[EN_W-1:0];
      if (cmd.neg) e_ff <= tneg ? (~p_ff + 1'b1) : p_ff;
      if (cmd.out_load) begin
         rsp_ff.node_energy <= e_ff;
         if (item_ff.last_node) begin
            rsp_ff.total_energy <= {es_rnd[EN_W-1], es_rnd[EN_W-1:1]};
            rsp_ff.total_valid  <= 1'b1;
         end else begin
            rsp_ff.total_energy <= '0;
            rsp_ff.total_valid  <= 1'b0;
         end
      end
   end

endmodule

`default_nettype wire

// File: hw/rtl/interface_line_tension_energy_unit.sv
// ----------------------------------------------------------------------------
// interface_line_tension_energy_unit
// Interface line-tension energy of a two-component mesh, one edge per item.
// ----------------------------------------------------------------------------
// Items are taken one at a time. An edge whose ends share a component goes
// from ST_DECIDE back to ST_IDLE unless it ends the node; an item that only
// ends a node goes straight to the energy states ST_MLO to ST_OUT, plus any
// wait for the result register. An edge between components runs the
// one-bit-per-cycle remainder unit that wraps each periodic axis and the
// one-bit-per-cycle square root, then the energy states when it ends the
// node. A non-periodic axis, or one with a zero box length, skips its remainder pass. The result register
// lets a finished result wait while the next item is accepted.
`default_nettype none

module interface_line_tension_energy_unit (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            req_valid,
   output logic                                 req_stall,
   input  wire ilte_pkg::req_type               req_data,
   output logic                                 rsp_valid,
   input  wire logic                            rsp_stall,
   output ilte_pkg::rsp_type                    rsp_data,
   input  wire logic                            csr_psel,
   input  wire logic                            csr_penable,
   input  wire logic                            csr_pwrite,
   input  wire logic [ilte_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  wire logic [ilte_pkg::CSR_DATA_W-1:0] csr_pwdata,
   output logic      [ilte_pkg::CSR_DATA_W-1:0] csr_prdata,
   output logic                                 csr_pready
);
   import ilte_pkg::*;

   cfg_type  cfg;
   cmd_type  cmd;
   stat_type stat;

   // Configuration registers.
   ilte_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   // Sequencer.
   ilte_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .stat      (stat),
      .cmd       (cmd)
   );

   // Arithmetic and result register.
   ilte_dp u_dp (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .cfg       (cfg),
      .cmd       (cmd),
      .stat      (stat)
   );

endmodule

`default_nettype wire
